### src/sfla_pkg.sv
`default_nettype none

package sfla_pkg;

  localparam int unsigned HEAP_GRANULES_DEF = 1024;
  localparam int unsigned GRANULE_BYTES_DEF = 32;
  localparam int unsigned SMALL_CLASSES_DEF = 32;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_RST = 1024;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_GRANULES_IN_USE = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT    = 3'd0,
    REQ_ALLOC   = 3'd1,
    REQ_FREE    = 3'd2,
    REQ_MARK    = 3'd3,
    REQ_UNMARK  = 3'd4,
    REQ_SWEEP   = 3'd5,
    REQ_USAGE   = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    RSP_OK       = 2'd0,
    RSP_NO_SPACE = 2'd1,
    RSP_INVALID  = 2'd2
  } rsp_status_e;

  typedef enum logic [1:0] {
    BS_FREE  = 2'd0,
    BS_ALLOC = 2'd1,
    BS_MARK  = 2'd2
  } blk_st_e;

endpackage

`default_nettype wire

### src/sfla_req_if.sv
`default_nettype none

interface sfla_req_if import sfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, req_type, size_bytes, block_addr, input ready);
  modport sink (input valid, req_type, size_bytes, block_addr, output ready);
endinterface

`default_nettype wire

### src/sfla_rsp_if.sv
`default_nettype none

interface sfla_rsp_if import sfla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ADDR_W-1:0]  alloc_addr;
  logic [BYTES_W-1:0] used_bytes;
  logic [BYTES_W-1:0] total_free_bytes;
  logic [BYTES_W-1:0] max_free_bytes;

  modport source (output valid, status, alloc_addr, used_bytes, total_free_bytes,
                  max_free_bytes, input ready);
  modport sink (input valid, status, alloc_addr, used_bytes, total_free_bytes,
                max_free_bytes, output ready);
endinterface

`default_nettype wire

### src/sfla_gdiv.sv
`default_nettype none

module sfla_gdiv import sfla_pkg::*; #(
  parameter int unsigned GRANULE_BYTES = GRANULE_BYTES_DEF,
  localparam int unsigned DW = $clog2(32'd65536 + GRANULE_BYTES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SIZE_W-1:0] size_i,
  output logic                   done_o,
  output logic [DW-1:0]          gran_o
);

  localparam int unsigned KW = DW + $clog2(GRANULE_BYTES);
  localparam int unsigned MW = DW + 2;
  localparam int unsigned PW = DW + MW;
  localparam longint unsigned RECIP =
    ((64'd1 << KW) + 64'(GRANULE_BYTES) - 64'd1) / 64'(GRANULE_BYTES);

  logic          done_q;
  logic [DW-1:0] quo_q;
  logic [DW-1:0] num;
  logic [PW-1:0] prod;

  // ceil(size / granule) by reciprocal multiply, exact for any DW-bit numerator
  assign num    = DW'(size_i) + DW'(GRANULE_BYTES - 1);
  assign prod   = PW'(num) * PW'(RECIP);
  assign done_o = done_q;
  assign gran_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) quo_q <= DW'(prod >> KW);
  end

endmodule

`default_nettype wire

### src/segregated_free_list_heap_allocator.sv
// Heap manager over HEAP_GRANULES granules of GRANULE_BYTES bytes. Block headers
// (status, size) and free-list links sit in two memories, each with one write
// port and one registered read port; list heads are flops. One request is worked
// at a time; the next request is taken as soon as the previous result is in the
// output register. Init writes one free block over the whole heap and lists it.
// Free and mark walk the headers from granule 0, block by block; unmark, sweep
// and usage walk every block. Alloc: granule count, then small lists tried, then
// large-list entries checked, then the split and the header write-back.
// Heap extent is set by granules_in_use (offset 0); write it only while idle.
`default_nettype none

module segregated_free_list_heap_allocator import sfla_pkg::*; #(
  parameter int unsigned HEAP_GRANULES = HEAP_GRANULES_DEF,
  parameter int unsigned GRANULE_BYTES = GRANULE_BYTES_DEF,
  parameter int unsigned SMALL_CLASSES = SMALL_CLASSES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  sfla_req_if.sink               req_i,
  sfla_rsp_if.source             rsp_o
);

  localparam int unsigned AW   = $clog2(HEAP_GRANULES);
  localparam int unsigned GW   = $clog2(HEAP_GRANULES + 1);
  localparam int unsigned LW   = AW + 1;
  localparam int unsigned HW   = GW + 2;
  localparam int unsigned SCW  = $clog2(SMALL_CLASSES);
  localparam int unsigned TW   = (GW > SCW + 1) ? GW : SCW + 1;
  localparam int unsigned SUMW = GW + 1;
  localparam int unsigned PW   = SUMW + $clog2(GRANULE_BYTES + 1);
  localparam int unsigned DW   = $clog2(32'd65536 + GRANULE_BYTES);
  localparam logic [LW-1:0] NIL = {LW{1'b1}};

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DISPATCH = 13'b0000000000010,
    S_DIV      = 13'b0000000000100,
    S_SMALL    = 13'b0000000001000,
    S_POP      = 13'b0000000010000,
    S_LG_EX    = 13'b0000000100000,
    S_SPLIT    = 13'b0000001000000,
    S_ALLOC_WR = 13'b0000010000000,
    S_WALK_RD  = 13'b0000100000000,
    S_WALK_EX  = 13'b0001000000000,
    S_SWEEP_END= 13'b0010000000000,
    S_CONV     = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_e;

  // configuration
  logic [CFG_W-1:0] cfg_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GRANULES_IN_USE);
  assign prdata = (paddr[2] == REG_GRANULES_IN_USE) ? APB_DW'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= CFG_W'(CFG_RST);
    else if (cfg_wr) cfg_q <= pwdata[CFG_W-1:0];
  end

  // memories
  logic [HW-1:0] hdr_mem [HEAP_GRANULES];
  logic [LW-1:0] link_mem [HEAP_GRANULES];
  logic [HW-1:0] hdr_rd_q;
  logic [LW-1:0] link_rd_q;
  logic [AW-1:0] rd_addr;
  logic          hdr_we, link_we;
  logic [AW-1:0] hdr_wa, link_wa;
  logic [HW-1:0] hdr_wd;
  logic [LW-1:0] link_wd;

  always_ff @(posedge clk_i) begin
    hdr_rd_q  <= hdr_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
  end

  logic [1:0]    hrd_st;
  logic [GW-1:0] hrd_gran;
  assign hrd_st   = hdr_rd_q[HW-1:GW];
  assign hrd_gran = hdr_rd_q[GW-1:0];

  // granule count divider
  logic          div_start, div_done;
  logic [DW-1:0] div_q;

  // control and working registers
  state_e            state_q, state_d;
  logic [REQ_W-1:0]  op_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;
  logic [GW-1:0]     heap_end_q, heap_end_d;
  logic [LW-1:0]     heads_q [SMALL_CLASSES];
  logic [LW-1:0]     heads_d [SMALL_CLASSES];
  logic [LW-1:0]     large_q, large_d;
  logic [GW-1:0]     g_q, g_d;
  logic [TW-1:0]     att_q, att_d;
  logic [LW-1:0]     b_q, b_d;
  logic [LW-1:0]     prev_q, prev_d;
  logic [GW-1:0]     steps_q, steps_d;
  logic [GW-1:0]     gran_q, gran_d;
  logic [AW-1:0]     scan_q, scan_d;
  logic              prev_free_q, prev_free_d;
  logic [GW-1:0]     prev_gran_q, prev_gran_d;
  logic [SUMW-1:0]   ug_q, ug_d, fg_q, fg_d, mg_q, mg_d;
  logic              mark_q, mark_d;
  logic [1:0]        conv_q, conv_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [ADDR_W-1:0] aaddr_q, aaddr_d;
  logic [BYTES_W-1:0] ub_q, ub_d, fb_q, fb_d, mb_q, mb_d;

  logic               rsp_valid_q;
  logic [STAT_W-1:0]  rsp_stat_q;
  logic [ADDR_W-1:0]  rsp_addr_q;
  logic [BYTES_W-1:0] rsp_ub_q, rsp_fb_q, rsp_mb_q;
  logic               rsp_load;

  logic          req_acc;
  logic          la_en, la_clr;
  logic [AW-1:0] la_blk;
  logic [GW-1:0] la_gran;
  logic [SCW-1:0] la_idx;
  logic [SCW-1:0] att_idx;
  logic [GW:0]   nscan;
  logic          cont;
  logic [GW-1:0] n_init;
  logic [DW-1:0] g_calc;
  logic [LW-1:0] head_b;
  logic [GW-1:0] steps_n;
  logic [SUMW-1:0] conv_val;
  logic [PW-1:0] prod;
  logic [BYTES_W-1:0] prod_sat;

  sfla_gdiv #(.GRANULE_BYTES(GRANULE_BYTES)) u_gdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .size_i  (size_q),
    .done_o  (div_done),
    .gran_o  (div_q)
  );

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign att_idx     = att_q[SCW-1:0];
  assign head_b      = heads_q[att_idx];
  assign nscan       = (GW+1)'(scan_q) + (GW+1)'(hrd_gran);
  assign cont        = (hrd_gran != '0) && (nscan < (GW+1)'(heap_end_q));
  assign g_calc      = (div_q == '0) ? DW'(1) : div_q;
  assign steps_n     = steps_q + 1'b1;

  always_comb begin
    if (cfg_q == '0) n_init = GW'(1);
    else if (32'(cfg_q) > HEAP_GRANULES) n_init = GW'(HEAP_GRANULES);
    else n_init = GW'(cfg_q);
  end

  always_comb begin
    case (conv_q)
      2'd0:    conv_val = ug_q;
      2'd1:    conv_val = fg_q;
      default: conv_val = mg_q;
    endcase
    prod     = PW'(conv_val) * PW'(GRANULE_BYTES);
    prod_sat = (prod > PW'(16'hFFFF)) ? 16'hFFFF : BYTES_W'(prod);
  end

  always_comb begin
    state_d     = state_q;
    heap_end_d  = heap_end_q;
    heads_d     = heads_q;
    large_d     = large_q;
    g_d         = g_q;
    att_d       = att_q;
    b_d         = b_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    gran_d      = gran_q;
    scan_d      = scan_q;
    prev_free_d = prev_free_q;
    prev_gran_d = prev_gran_q;
    ug_d        = ug_q;
    fg_d        = fg_q;
    mg_d        = mg_q;
    mark_d      = mark_q;
    conv_d      = conv_q;
    stat_d      = stat_q;
    aaddr_d     = aaddr_q;
    ub_d        = ub_q;
    fb_d        = fb_q;
    mb_d        = mb_q;
    rd_addr     = scan_q;
    hdr_we      = 1'b0;
    hdr_wa      = scan_q;
    hdr_wd      = '0;
    link_we     = 1'b0;
    link_wa     = '0;
    link_wd     = '0;
    la_en       = 1'b0;
    la_clr      = 1'b0;
    la_blk      = '0;
    la_gran     = '0;
    div_start   = 1'b0;
    rsp_load    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          stat_d  = RSP_OK;
          aaddr_d = '0;
          ub_d    = '0;
          fb_d    = '0;
          mb_d    = '0;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        scan_d      = '0;
        prev_free_d = 1'b0;
        prev_d      = NIL;
        ug_d        = '0;
        fg_d        = '0;
        mg_d        = '0;
        mark_d      = 1'b0;
        conv_d      = '0;
        case (op_q)
          REQ_INIT: begin
            heap_end_d = n_init;
            hdr_we     = 1'b1;
            hdr_wa     = '0;
            hdr_wd     = {BS_FREE, n_init};
            la_clr     = 1'b1;
            la_en      = 1'b1;
            la_blk     = '0;
            la_gran    = n_init;
            state_d    = S_DONE;
          end
          REQ_ALLOC: begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
          REQ_FREE, REQ_MARK: begin
            if (heap_end_q == '0) begin
              stat_d  = RSP_INVALID;
              state_d = S_DONE;
            end else begin
              state_d = S_WALK_RD;
            end
          end
          REQ_UNMARK, REQ_SWEEP, REQ_USAGE: begin
            if (op_q == REQ_SWEEP) la_clr = 1'b1;
            if (heap_end_q == '0) state_d = (op_q == REQ_USAGE) ? S_CONV : S_DONE;
            else state_d = S_WALK_RD;
          end
          default: begin
            stat_d  = RSP_INVALID;
            state_d = S_DONE;
          end
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          if (32'(g_calc) > 32'(heap_end_q)) begin
            stat_d  = RSP_NO_SPACE;
            state_d = S_DONE;
          end else begin
            g_d     = GW'(g_calc);
            att_d   = TW'(g_calc);
            state_d = S_SMALL;
          end
        end
      end

      S_SMALL: begin
        if (32'(att_q) < SMALL_CLASSES) begin
          if (head_b < LW'(HEAP_GRANULES)) begin
            rd_addr = head_b[AW-1:0];
            b_d     = head_b;
            state_d = S_POP;
          end else begin
            att_d = {att_q[TW-2:0], 1'b0};
          end
        end else begin
          prev_d  = NIL;
          steps_d = '0;
          if (large_q < LW'(HEAP_GRANULES)) begin
            rd_addr = large_q[AW-1:0];
            b_d     = large_q;
            state_d = S_LG_EX;
          end else begin
            stat_d  = RSP_NO_SPACE;
            state_d = S_DONE;
          end
        end
      end

      S_POP: begin
        heads_d[att_idx] = link_rd_q;
        gran_d           = hrd_gran;
        state_d          = S_SPLIT;
      end

      S_LG_EX: begin
        if (hrd_gran >= g_q) begin
          if (prev_q == NIL) begin
            large_d = link_rd_q;
          end else begin
            link_we = 1'b1;
            link_wa = prev_q[AW-1:0];
            link_wd = link_rd_q;
          end
          gran_d  = hrd_gran;
          state_d = S_SPLIT;
        end else begin
          prev_d  = b_q;
          steps_d = steps_n;
          if ((link_rd_q < LW'(HEAP_GRANULES)) && (32'(steps_n) < HEAP_GRANULES)) begin
            rd_addr = link_rd_q[AW-1:0];
            b_d     = link_rd_q;
          end else begin
            stat_d  = RSP_NO_SPACE;
            state_d = S_DONE;
          end
        end
      end

      S_SPLIT: begin
        if (gran_q != g_q) begin
          hdr_we  = 1'b1;
          hdr_wa  = b_q[AW-1:0] + AW'(g_q);
          hdr_wd  = {BS_FREE, gran_q - g_q};
          la_en   = 1'b1;
          la_blk  = b_q[AW-1:0] + AW'(g_q);
          la_gran = gran_q - g_q;
        end
        state_d = S_ALLOC_WR;
      end

      S_ALLOC_WR: begin
        hdr_we  = 1'b1;
        hdr_wa  = b_q[AW-1:0];
        hdr_wd  = {BS_ALLOC, g_q};
        aaddr_d = ADDR_W'(b_q[AW-1:0]);
        state_d = S_DONE;
      end

      S_WALK_RD: begin
        rd_addr = scan_q;
        state_d = S_WALK_EX;
      end

      S_WALK_EX: begin
        case (op_q)
          REQ_FREE, REQ_MARK: begin
            if (32'(scan_q) == 32'(addr_q)) begin
              if (hrd_st == BS_FREE) begin
                stat_d = RSP_INVALID;
              end else begin
                hdr_we = 1'b1;
                hdr_wa = scan_q;
                if (op_q == REQ_FREE) begin
                  hdr_wd  = {BS_FREE, hrd_gran};
                  la_en   = 1'b1;
                  la_blk  = scan_q;
                  la_gran = hrd_gran;
                end else begin
                  hdr_wd = {BS_MARK, hrd_gran};
                end
              end
              state_d = S_DONE;
            end else if (!cont) begin
              stat_d  = RSP_INVALID;
              state_d = S_DONE;
            end else begin
              scan_d  = AW'(nscan);
              state_d = S_WALK_RD;
            end
          end
          REQ_UNMARK: begin
            if ((hrd_gran != '0) && (hrd_st == BS_MARK)) begin
              hdr_we = 1'b1;
              hdr_wa = scan_q;
              hdr_wd = {BS_ALLOC, hrd_gran};
            end
            scan_d  = AW'(nscan);
            state_d = cont ? S_WALK_RD : S_DONE;
          end
          REQ_USAGE: begin
            if (hrd_gran != '0) begin
              if (hrd_st == BS_FREE) begin
                fg_d = fg_q + SUMW'(hrd_gran);
                if (SUMW'(hrd_gran) > mg_q) mg_d = SUMW'(hrd_gran);
              end else begin
                ug_d = ug_q + SUMW'(hrd_gran);
                if (hrd_st == BS_MARK) mark_d = 1'b1;
              end
            end
            scan_d  = AW'(nscan);
            state_d = cont ? S_WALK_RD : S_CONV;
          end
          default: begin
            if (hrd_gran != '0) begin
              if (hrd_st == BS_MARK) begin
                if (prev_free_q) begin
                  la_en   = 1'b1;
                  la_blk  = prev_q[AW-1:0];
                  la_gran = prev_gran_q;
                end
                hdr_we      = 1'b1;
                hdr_wa      = scan_q;
                hdr_wd      = {BS_ALLOC, hrd_gran};
                prev_d      = LW'(scan_q);
                prev_free_d = 1'b0;
                prev_gran_d = hrd_gran;
              end else if (prev_free_q) begin
                hdr_we      = 1'b1;
                hdr_wa      = prev_q[AW-1:0];
                hdr_wd      = {BS_FREE, prev_gran_q + hrd_gran};
                prev_gran_d = prev_gran_q + hrd_gran;
              end else begin
                hdr_we      = 1'b1;
                hdr_wa      = scan_q;
                hdr_wd      = {BS_FREE, hrd_gran};
                prev_d      = LW'(scan_q);
                prev_free_d = 1'b1;
                prev_gran_d = hrd_gran;
              end
            end
            scan_d  = AW'(nscan);
            state_d = cont ? S_WALK_RD : S_SWEEP_END;
          end
        endcase
      end

      S_SWEEP_END: begin
        if (prev_free_q) begin
          la_en   = 1'b1;
          la_blk  = prev_q[AW-1:0];
          la_gran = prev_gran_q;
        end
        state_d = S_DONE;
      end

      S_CONV: begin
        case (conv_q)
          2'd0:    ub_d = prod_sat;
          2'd1:    fb_d = prod_sat;
          default: mb_d = prod_sat;
        endcase
        conv_d = conv_q + 1'b1;
        if (conv_q == 2'd2) begin
          if (mark_q) stat_d = RSP_INVALID;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // clear all lists on request, and push a block onto the list for its size
    la_idx = la_gran[SCW-1:0];
    if (la_clr) begin
      for (int i = 0; i < SMALL_CLASSES; i++) heads_d[i] = NIL;
      large_d = NIL;
    end
    if (la_en) begin
      link_we = 1'b1;
      link_wa = la_blk;
      if (32'(la_gran) < SMALL_CLASSES) begin
        link_wd         = la_clr ? NIL : heads_q[la_idx];
        heads_d[la_idx] = LW'(la_blk);
      end else begin
        link_wd = la_clr ? NIL : large_q;
        large_d = LW'(la_blk);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_end_q  <= '0;
      large_q     <= NIL;
      for (int i = 0; i < SMALL_CLASSES; i++) heads_q[i] <= NIL;
      rsp_valid_q <= 1'b0;
      prev_free_q <= 1'b0;
      mark_q      <= 1'b0;
      conv_q      <= '0;
    end else begin
      state_q     <= state_d;
      heap_end_q  <= heap_end_d;
      large_q     <= large_d;
      heads_q     <= heads_d;
      prev_free_q <= prev_free_d;
      mark_q      <= mark_d;
      conv_q      <= conv_d;
      if (rsp_load) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q   <= req_i.req_type;
      size_q <= req_i.size_bytes;
      addr_q <= req_i.block_addr;
    end
    g_q         <= g_d;
    att_q       <= att_d;
    b_q         <= b_d;
    prev_q      <= prev_d;
    steps_q     <= steps_d;
    gran_q      <= gran_d;
    scan_q      <= scan_d;
    prev_gran_q <= prev_gran_d;
    ug_q        <= ug_d;
    fg_q        <= fg_d;
    mg_q        <= mg_d;
    stat_q      <= stat_d;
    aaddr_q     <= aaddr_d;
    ub_q        <= ub_d;
    fb_q        <= fb_d;
    mb_q        <= mb_d;
    if (rsp_load) begin
      rsp_stat_q <= stat_q;
      rsp_addr_q <= aaddr_q;
      rsp_ub_q   <= ub_q;
      rsp_fb_q   <= fb_q;
      rsp_mb_q   <= mb_q;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = rsp_stat_q;
  assign rsp_o.alloc_addr       = rsp_addr_q;
  assign rsp_o.used_bytes       = rsp_ub_q;
  assign rsp_o.total_free_bytes = rsp_fb_q;
  assign rsp_o.max_free_bytes   = rsp_mb_q;

endmodule

`default_nettype wire
